FILE: src/aeu_pkg.sv
package aeu_pkg;

  // Fixed field geometry of the ports
  localparam int PORT_W     = 32;
  localparam int COEF_W     = 16;
  localparam int FIELD_AXES = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd3;

  // Reset values: 10.0, 100.0 and 1.0 in Q8.8 on every axis, ts about 0.01 s
  localparam logic [CFG_DATA_W-1:0] STIFFNESS_RESET = 64'h0A00_0A00_0A00_0A00;
  localparam logic [CFG_DATA_W-1:0] DAMPING_RESET   = 64'h6400_6400_6400_6400;
  localparam logic [CFG_DATA_W-1:0] INV_MASS_RESET  = 64'h0100_0100_0100_0100;
  localparam logic [COEF_W-1:0]     STEP_TIME_RESET = 16'd655;

  typedef enum logic [1:0] {
    ACT_MEASURE    = 2'd0,
    ACT_REFERENCE  = 2'd1,
    ACT_ACTIVATION = 2'd2,
    ACT_SATURATION = 2'd3
  } action_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] stiffness;
    logic [CFG_DATA_W-1:0] damping;
    logic [CFG_DATA_W-1:0] inv_mass;
    logic [COEF_W-1:0]     step_time;
    logic                  activation;
    logic                  saturation;
  } coef_set_t;

  typedef struct packed {
    logic vld;
    logic tail;
  } step_tag_t;

endpackage

FILE: src/admittance_euler_four_axis_unit.sv
// Reference step: axes stream one per cycle through a 6-deep pipeline.
// Measurement update: one measurement memory write per axis.
// Flag requests: applied when taken. A new request is taken only once the previous one is done;
//   a finished result waits in the output register without blocking intake.
// Reset (synchronous, rst_n low): coefficients to defaults, flags and valid bits clear.
module admittance_euler_four_axis_unit #(
  parameter int NUM_AXES    = 4,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_action,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_ref_force_x,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_ref_force_z,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_ref_torque_theta,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_ref_torque_psi,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_meas_force_x,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_meas_force_z,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_meas_torque_y,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_meas_torque_z,
  input  logic                                in_pin_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [aeu_pkg::PORT_W-1:0]   out_pos_x,
  output logic signed [aeu_pkg::PORT_W-1:0]   out_pos_z,
  output logic signed [aeu_pkg::PORT_W-1:0]   out_pos_theta,
  output logic signed [aeu_pkg::PORT_W-1:0]   out_pos_psi,
  output logic signed [aeu_pkg::PORT_W-1:0]   out_vel_x,
  output logic signed [aeu_pkg::PORT_W-1:0]   out_vel_z,
  output logic signed [aeu_pkg::PORT_W-1:0]   out_vel_theta,
  output logic signed [aeu_pkg::PORT_W-1:0]   out_vel_psi,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aeu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aeu_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import aeu_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int AXIS_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int EXT_W  = ((VW > PORT_W) ? VW : PORT_W) + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MEAS  = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  // Port value into the internal range, saturating when the range is narrower
  function automatic logic signed [VW-1:0] to_val(input logic signed [PORT_W-1:0] x);
    logic signed [EXT_W-1:0] xe;
    logic signed [EXT_W-1:0] vmax;
    logic signed [EXT_W-1:0] vmin;
    xe   = EXT_W'(x);
    vmax = EXT_W'({(VW-1){1'b1}});
    vmin = ~vmax;
    if (xe > vmax) begin
      to_val = vmax[VW-1:0];
    end else if (xe < vmin) begin
      to_val = vmin[VW-1:0];
    end else begin
      to_val = xe[VW-1:0];
    end
  endfunction

  // Internal value onto a port: sign-extend or keep the low bits
  function automatic logic [PORT_W-1:0] to_port(input logic signed [VW-1:0] x);
    logic signed [EXT_W-1:0] xe;
    xe      = EXT_W'(x);
    to_port = xe[PORT_W-1:0];
  endfunction

  state_t                   state_r, state_nxt;
  logic [AXIS_W-1:0]        cnt_r;
  logic                     cnt_tail;
  coef_set_t                coef_r;
  logic                     seen_r;
  logic [NUM_AXES-1:0]      pv_ok_r;
  logic [NUM_AXES-1:0]      meas_ok_r;

  logic signed [VW-1:0]     ref_r      [FIELD_AXES];
  logic signed [VW-1:0]     meas_cap_r [FIELD_AXES];
  logic signed [VW-1:0]     stage_pos_r [FIELD_AXES];
  logic signed [VW-1:0]     stage_vel_r [FIELD_AXES];
  logic [PORT_W-1:0]        out_pos_r  [FIELD_AXES];
  logic [PORT_W-1:0]        out_vel_r  [FIELD_AXES];
  logic                     out_valid_r;

  logic                     in_acc;
  logic                     emit_go;
  logic                     iss_en;
  step_tag_t                iss_tag_r;
  logic [AXIS_W-1:0]        iss_axis_r;
  logic                     rd_pv_ok_r;
  logic                     rd_meas_ok_r;

  logic signed [PORT_W-1:0] in_ref_w  [FIELD_AXES];
  logic signed [PORT_W-1:0] in_meas_w [FIELD_AXES];

  logic                     meas_we;
  logic signed [VW-1:0]     meas_wdata;
  logic [VW-1:0]            meas_rdata;
  logic [2*VW-1:0]          pv_rdata;

  logic signed [VW-1:0]     p_pos, p_vel, p_ref, p_meas;
  step_tag_t                wb_tag;
  logic [AXIS_W-1:0]        wb_axis;
  logic signed [VW-1:0]     wb_pos, wb_vel;

  assign in_ref_w[0]  = in_ref_force_x;
  assign in_ref_w[1]  = in_ref_force_z;
  assign in_ref_w[2]  = in_ref_torque_theta;
  assign in_ref_w[3]  = in_ref_torque_psi;
  assign in_meas_w[0] = in_meas_force_x;
  assign in_meas_w[1] = in_meas_force_z;
  assign in_meas_w[2] = in_meas_torque_y;
  assign in_meas_w[3] = in_meas_torque_z;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cnt_tail  = (cnt_r == AXIS_W'(NUM_AXES - 1));
  assign iss_en    = (state_r == S_RUN);
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // Sequencer: walk the axes once per measurement or reference request, then hand off a step's result
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (action_t'(in_action))
            ACT_MEASURE:   state_nxt = S_MEAS;
            ACT_REFERENCE: state_nxt = seen_r ? S_RUN : S_IDLE;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_MEAS:  if (cnt_tail) state_nxt = S_IDLE;
      S_RUN:   if (cnt_tail) state_nxt = S_DRAIN;
      S_DRAIN: if (wb_tag.vld && wb_tag.tail) state_nxt = S_EMIT;
      S_EMIT:  if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= S_IDLE;
      cnt_r               <= '0;
      seen_r              <= 1'b0;
      pv_ok_r             <= '0;
      meas_ok_r           <= '0;
      out_valid_r         <= 1'b0;
      iss_tag_r           <= '0;
      coef_r.stiffness    <= STIFFNESS_RESET;
      coef_r.damping      <= DAMPING_RESET;
      coef_r.inv_mass     <= INV_MASS_RESET;
      coef_r.step_time    <= STEP_TIME_RESET;
      coef_r.activation   <= 1'b0;
      coef_r.saturation   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Advance the axis counter while writing measurements or issuing reads
      if (state_r == S_MEAS || state_r == S_RUN) begin
        cnt_r <= cnt_tail ? '0 : cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end

      if (meas_we) begin
        meas_ok_r[cnt_r] <= 1'b1;
        if (cnt_tail) begin
          seen_r <= 1'b1;
        end
      end
      if (wb_tag.vld) begin
        pv_ok_r[wb_axis] <= 1'b1;
      end

      iss_tag_r.vld  <= iss_en;
      iss_tag_r.tail <= iss_en && cnt_tail;

      // Flag requests take effect at once
      if (in_acc && action_t'(in_action) == ACT_ACTIVATION) begin
        coef_r.activation <= in_pin_value;
      end
      if (in_acc && action_t'(in_action) == ACT_SATURATION) begin
        coef_r.saturation <= in_pin_value;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STIFFNESS: coef_r.stiffness <= cfg_data;
          REG_DAMPING:   coef_r.damping   <= cfg_data;
          REG_INV_MASS:  coef_r.inv_mass  <= cfg_data;
          REG_STEP_TIME: coef_r.step_time <= cfg_data[COEF_W-1:0];
          default:       ;
        endcase
      end

      // Hold the result until taken; load the next one when the slot frees
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < FIELD_AXES; i++) begin
        ref_r[i]      <= to_val(in_ref_w[i]);
        meas_cap_r[i] <= to_val(in_meas_w[i]);
      end
    end
    iss_axis_r   <= cnt_r;
    rd_pv_ok_r   <= pv_ok_r[cnt_r];
    rd_meas_ok_r <= meas_ok_r[cnt_r];
    if (wb_tag.vld && int'(wb_axis) < FIELD_AXES) begin
      stage_pos_r[2'(wb_axis)] <= wb_pos;
      stage_vel_r[2'(wb_axis)] <= wb_vel;
    end
    if (emit_go) begin
      for (int i = 0; i < FIELD_AXES; i++) begin
        out_pos_r[i] <= (i < NUM_AXES) ? to_port(stage_pos_r[i]) : '0;
        out_vel_r[i] <= (i < NUM_AXES) ? to_port(stage_vel_r[i]) : '0;
      end
    end
  end

  // Measurement memory: axes past the port fields latch zero
  assign meas_we    = (state_r == S_MEAS);
  assign meas_wdata = (int'(cnt_r) < FIELD_AXES) ? meas_cap_r[2'(cnt_r)] : '0;

  aeu_ram #(
    .WIDTH (VW),
    .DEPTH (NUM_AXES)
  ) u_meas_ram (
    .clk   (clk),
    .we    (meas_we),
    .waddr (cnt_r),
    .wdata (meas_wdata),
    .raddr (cnt_r),
    .rdata (meas_rdata)
  );

  // Position/velocity memory: read at issue, written back from the pipeline tail
  aeu_ram #(
    .WIDTH (2 * VW),
    .DEPTH (NUM_AXES)
  ) u_pv_ram (
    .clk   (clk),
    .we    (wb_tag.vld),
    .waddr (wb_axis),
    .wdata ({wb_vel, wb_pos}),
    .raddr (cnt_r),
    .rdata (pv_rdata)
  );

  // Entries never written read as zero
  assign p_pos  = rd_pv_ok_r ? pv_rdata[VW-1:0] : '0;
  assign p_vel  = rd_pv_ok_r ? pv_rdata[2*VW-1:VW] : '0;
  assign p_meas = rd_meas_ok_r ? meas_rdata : '0;
  assign p_ref  = (int'(iss_axis_r) < FIELD_AXES) ? ref_r[2'(iss_axis_r)] : '0;

  aeu_axis_pipe #(
    .NUM_AXES    (NUM_AXES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (coef_r),
    .in_tag  (iss_tag_r),
    .in_axis (iss_axis_r),
    .in_pos  (p_pos),
    .in_vel  (p_vel),
    .in_ref  (p_ref),
    .in_meas (p_meas),
    .wb_tag  (wb_tag),
    .wb_axis (wb_axis),
    .wb_pos  (wb_pos),
    .wb_vel  (wb_vel)
  );

  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_pos_r[0];
  assign out_pos_z     = out_pos_r[1];
  assign out_pos_theta = out_pos_r[2];
  assign out_pos_psi   = out_pos_r[3];
  assign out_vel_x     = out_vel_r[0];
  assign out_vel_z     = out_vel_r[1];
  assign out_vel_theta = out_vel_r[2];
  assign out_vel_psi   = out_vel_r[3];

  a_wb_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    wb_tag.vld |-> (state_r == S_RUN || state_r == S_DRAIN))
    else $error("writeback outside a reference step");

  a_run_needs_meas: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> seen_r)
    else $error("reference step started before any measurement");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_EMIT))
    else $error("result raised outside the hand-off state");

  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid && !out_ready) |=> (state_r == S_EMIT))
    else $error("pending result overwritten while the output stalls");

endmodule

FILE: src/aeu_ram.sv
module aeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/aeu_axis_pipe.sv
module aeu_axis_pipe #(
  parameter int NUM_AXES    = 4,
  parameter int VALUE_WIDTH = 32,
  localparam int AXIS_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  aeu_pkg::coef_set_t            cfg,
  input  aeu_pkg::step_tag_t            in_tag,
  input  logic [AXIS_W-1:0]             in_axis,
  input  logic signed [VALUE_WIDTH-1:0] in_pos,
  input  logic signed [VALUE_WIDTH-1:0] in_vel,
  input  logic signed [VALUE_WIDTH-1:0] in_ref,
  input  logic signed [VALUE_WIDTH-1:0] in_meas,
  output aeu_pkg::step_tag_t            wb_tag,
  output logic [AXIS_W-1:0]             wb_axis,
  output logic signed [VALUE_WIDTH-1:0] wb_pos,
  output logic signed [VALUE_WIDTH-1:0] wb_vel
);
  import aeu_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int PW = VW + COEF_W + 1;  // coefficient times value
  localparam int SW = VW + COEF_W + 3;  // force sum and saturation width

  function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] vmax;
    logic signed [SW-1:0] vmin;
    vmax = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    vmin = ~vmax;
    if (x > vmax) begin
      sat_v = vmax[VW-1:0];
    end else if (x < vmin) begin
      sat_v = vmin[VW-1:0];
    end else begin
      sat_v = x[VW-1:0];
    end
  endfunction

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] x);
    mag = x[VW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [COEF_W-1:0] coef16(input logic [CFG_DATA_W-1:0] packed_c,
                                               input logic [1:0] sel);
    coef16 = packed_c[{sel, 4'b0000} +: COEF_W];
  endfunction

  // Tags and carried state, index k holds stage k+1
  step_tag_t                tag_r  [5];
  logic [AXIS_W-1:0]        axis_r [5];
  logic signed [VW-1:0]     pos_r  [5];
  logic signed [VW-1:0]     vel_r  [5];

  logic signed [VW-1:0]     s1_err_r;
  logic signed [PW-1:0]     s1_pk_r;
  logic signed [PW-1:0]     s1_pd_r;
  logic signed [PW-1:0]     s1_pvt_r;
  logic signed [VW-1:0]     s2_inner_r;
  logic signed [VW-1:0]     s2_npos_r;
  logic signed [PW-1:0]     s3_pm_r;
  logic signed [VW-1:0]     s3_fpos_r;
  logic                     s3_hold_r;
  logic signed [VW-1:0]     s4_accel_r;
  logic signed [VW-1:0]     s4_fpos_r;
  logic                     s4_hold_r;
  logic signed [PW-1:0]     s5_pa_r;
  logic signed [VW-1:0]     s5_fpos_r;
  logic                     s5_hold_r;

  logic [1:0]               sel0;
  logic signed [VW:0]       diff0;
  logic signed [VW-1:0]     err0;
  logic signed [PW-1:0]     pk0;
  logic signed [PW-1:0]     pd0;
  logic signed [PW-1:0]     pvt0;
  logic signed [SW-1:0]     sum1;
  logic signed [VW-1:0]     inner1;
  logic signed [VW-1:0]     npos1;
  logic signed [PW-1:0]     pm2;
  logic                     hold2;
  logic signed [VW-1:0]     accel3;
  logic signed [PW-1:0]     pa4;
  logic signed [VW-1:0]     nvel5;

  // Error, spring, damper and position products
  always_comb begin
    sel0  = 2'(in_axis);
    diff0 = (VW+1)'(in_ref) - (VW+1)'(in_meas);
    err0  = cfg.activation ? sat_v(SW'(diff0)) : '0;
    pk0   = $signed({1'b0, coef16(cfg.stiffness, sel0)}) * in_pos;
    pd0   = $signed({1'b0, coef16(cfg.damping, sel0)}) * in_vel;
    pvt0  = $signed({1'b0, cfg.step_time}) * in_vel;
  end

  // Force sum in Q24.24, floored back to Q16.16; new position
  always_comb begin
    sum1   = -SW'(s1_pk_r) - SW'(s1_pd_r) - (SW'(s1_err_r) <<< 8);
    inner1 = sat_v(sum1 >>> 8);
    npos1  = sat_v(SW'(pos_r[0]) + SW'(s1_pvt_r >>> 16));
  end

  // Scale by inverse mass; decide the saturation hold
  always_comb begin
    pm2   = $signed({1'b0, coef16(cfg.inv_mass, 2'(axis_r[1]))}) * s2_inner_r;
    hold2 = cfg.saturation && (mag(s2_npos_r) > mag(pos_r[1]));
  end

  always_comb begin
    accel3 = sat_v(SW'(s3_pm_r >>> 8));
    pa4    = $signed({1'b0, cfg.step_time}) * s4_accel_r;
    nvel5  = sat_v(SW'(vel_r[4]) + SW'(s5_pa_r >>> 16));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 5; s++) begin
        tag_r[s] <= '0;
      end
    end else begin
      tag_r[0] <= in_tag;
      for (int s = 1; s < 5; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    axis_r[0] <= in_axis;
    pos_r[0]  <= in_pos;
    vel_r[0]  <= in_vel;
    for (int s = 1; s < 5; s++) begin
      axis_r[s] <= axis_r[s-1];
      pos_r[s]  <= pos_r[s-1];
      vel_r[s]  <= vel_r[s-1];
    end
    s1_err_r   <= err0;
    s1_pk_r    <= pk0;
    s1_pd_r    <= pd0;
    s1_pvt_r   <= pvt0;
    s2_inner_r <= inner1;
    s2_npos_r  <= npos1;
    s3_pm_r    <= pm2;
    s3_hold_r  <= hold2;
    s3_fpos_r  <= hold2 ? pos_r[1] : s2_npos_r;
    s4_accel_r <= accel3;
    s4_fpos_r  <= s3_fpos_r;
    s4_hold_r  <= s3_hold_r;
    s5_pa_r    <= pa4;
    s5_fpos_r  <= s4_fpos_r;
    s5_hold_r  <= s4_hold_r;
  end

  assign wb_tag  = tag_r[4];
  assign wb_axis = axis_r[4];
  assign wb_pos  = s5_fpos_r;
  assign wb_vel  = s5_hold_r ? '0 : nvel5;

endmodule

FILE: bench/admittance_pose_checker.sv
`timescale 1ns / 1ps
module admittance_pose_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          in_action,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_ref_force_x,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_ref_force_z,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_ref_torque_theta,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_ref_torque_psi,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_meas_force_x,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_meas_force_z,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_meas_torque_y,
  input  logic signed [aeu_pkg::PORT_W-1:0]   in_meas_torque_z,
  input  logic                                in_pin_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [aeu_pkg::PORT_W-1:0]   out_pos_x,
  input  logic signed [aeu_pkg::PORT_W-1:0]   out_pos_z,
  input  logic signed [aeu_pkg::PORT_W-1:0]   out_pos_theta,
  input  logic signed [aeu_pkg::PORT_W-1:0]   out_pos_psi,
  input  logic signed [aeu_pkg::PORT_W-1:0]   out_vel_x,
  input  logic signed [aeu_pkg::PORT_W-1:0]   out_vel_z,
  input  logic signed [aeu_pkg::PORT_W-1:0]   out_vel_theta,
  input  logic signed [aeu_pkg::PORT_W-1:0]   out_vel_psi,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [aeu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aeu_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  checked
);
  import aeu_pkg::*;

  localparam longint Q16_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q16_MIN = -Q16_MAX - 1;

  typedef struct packed {
    logic [FIELD_AXES-1:0][PORT_W-1:0] pos;
    logic [FIELD_AXES-1:0][PORT_W-1:0] vel;
  } pose_t;

  logic [CFG_DATA_W-1:0] stiff_bank, damp_bank, inv_mass_bank;
  logic [COEF_W-1:0]     step_q;
  longint                pos_q [FIELD_AXES];
  longint                vel_q [FIELD_AXES];
  longint                meas_q [FIELD_AXES];
  bit                    seen_q, act_q, sat_q;
  pose_t                 pose_due [$];
  string                 axis_tag [FIELD_AXES] = '{"x", "z", "theta", "psi"};

  function automatic longint clip_q16(input longint v);
    if (v > Q16_MAX) return Q16_MAX;
    if (v < Q16_MIN) return Q16_MIN;
    return v;
  endfunction

  function automatic longint lane(input logic [CFG_DATA_W-1:0] bank, input int a);
    return longint'({48'd0, bank[a*COEF_W +: COEF_W]});
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // One forward Euler step on all axes; >>> on longint floors.
  function automatic pose_t advance_axes(input logic [FIELD_AXES-1:0][PORT_W-1:0] goal);
    pose_t  nxt;
    longint err, sum, inner, accel, npos, nvel, span;
    span = longint'({48'd0, step_q});
    for (int a = 0; a < FIELD_AXES; a++) begin
      err = act_q ? clip_q16(longint'(signed'(goal[a])) - meas_q[a]) : 0;
      // Q24.24 sum stays below 2^50 in magnitude, so no 64-bit clamp is needed
      sum = -(lane(stiff_bank, a) * pos_q[a]) - lane(damp_bank, a) * vel_q[a] - err * 256;
      inner = clip_q16(sum >>> 8);
      accel = clip_q16((inner * lane(inv_mass_bank, a)) >>> 8);
      nvel  = clip_q16(vel_q[a] + ((accel * span) >>> 16));
      npos  = clip_q16(pos_q[a] + ((vel_q[a] * span) >>> 16));
      if (sat_q && magnitude(npos) > magnitude(pos_q[a])) begin
        vel_q[a] = 0;
      end else begin
        vel_q[a] = nvel;
        pos_q[a] = npos;
      end
      nxt.pos[a] = pos_q[a][PORT_W-1:0];
      nxt.vel[a] = vel_q[a][PORT_W-1:0];
    end
    return nxt;
  endfunction

  task automatic note_field(input string name, input logic [PORT_W-1:0] due,
                            input logic [PORT_W-1:0] got);
    if (due !== got) begin
      if (fail_count < 10)
        $display("mismatch on %s: expected %0d, got %0d", name, signed'(due), signed'(got));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pose_t due, got;
    if (!rst_n) begin
      stiff_bank    = STIFFNESS_RESET;
      damp_bank     = DAMPING_RESET;
      inv_mass_bank = INV_MASS_RESET;
      step_q        = STEP_TIME_RESET;
      for (int a = 0; a < FIELD_AXES; a++) begin
        pos_q[a]  = 0;
        vel_q[a]  = 0;
        meas_q[a] = 0;
      end
      seen_q = 1'b0;
      act_q  = 1'b0;
      sat_q  = 1'b0;
      pose_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.pos = {out_pos_psi, out_pos_theta, out_pos_z, out_pos_x};
        got.vel = {out_vel_psi, out_vel_theta, out_vel_z, out_vel_x};
        if (pose_due.size() == 0) begin
          if (fail_count < 10)
            $display("result with no step pending: pos_x %0d vel_x %0d", out_pos_x, out_vel_x);
          fail_count++;
        end else begin
          due = pose_due.pop_front();
          for (int a = 0; a < FIELD_AXES; a++) begin
            note_field({"pos_", axis_tag[a]}, due.pos[a], got.pos[a]);
            note_field({"vel_", axis_tag[a]}, due.vel[a], got.vel[a]);
          end
          checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STIFFNESS: stiff_bank    = cfg_data;
          REG_DAMPING:   damp_bank     = cfg_data;
          REG_INV_MASS:  inv_mass_bank = cfg_data;
          REG_STEP_TIME: step_q        = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (action_t'(in_action))
          ACT_MEASURE: begin
            meas_q[0] = longint'(in_meas_force_x);
            meas_q[1] = longint'(in_meas_force_z);
            meas_q[2] = longint'(in_meas_torque_y);
            meas_q[3] = longint'(in_meas_torque_z);
            seen_q    = 1'b1;
          end
          ACT_ACTIVATION: act_q = in_pin_value;
          ACT_SATURATION: sat_q = in_pin_value;
          ACT_REFERENCE: begin
            if (seen_q)
              pose_due.push_back(advance_axes({in_ref_torque_psi, in_ref_torque_theta,
                                               in_ref_force_z, in_ref_force_x}));
          end
          default: ;
        endcase
      end
    end
    pending = pose_due.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import aeu_pkg::*;

  localparam logic [PORT_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [PORT_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [PORT_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;
  localparam int ROUNDS = 8;
  localparam int ROUND_REQUESTS = 200;
  // A measurement or flag request leaves nothing behind to wait for; give the
  // block at least its reference-step latency before touching the registers.
  localparam int SETTLE_CYCLES = 24;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  action_t                  in_action = ACT_MEASURE;
  logic signed [PORT_W-1:0] in_ref_force_x = '0;
  logic signed [PORT_W-1:0] in_ref_force_z = '0;
  logic signed [PORT_W-1:0] in_ref_torque_theta = '0;
  logic signed [PORT_W-1:0] in_ref_torque_psi = '0;
  logic signed [PORT_W-1:0] in_meas_force_x = '0;
  logic signed [PORT_W-1:0] in_meas_force_z = '0;
  logic signed [PORT_W-1:0] in_meas_torque_y = '0;
  logic signed [PORT_W-1:0] in_meas_torque_z = '0;
  logic                     in_pin_value = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [PORT_W-1:0] out_pos_x, out_pos_z, out_pos_theta, out_pos_psi;
  logic signed [PORT_W-1:0] out_vel_x, out_vel_z, out_vel_theta, out_vel_psi;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_STIFFNESS;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  int fail_count, pending, checked;
  int idle_pct = 0;        // chance per cycle that the sender holds back
  int stall_pct = 0;       // chance per cycle that the receiver stalls
  int requests_sent = 0;

  always #4 clk = ~clk;

  admittance_euler_four_axis_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_ref_force_x(in_ref_force_x), .in_ref_force_z(in_ref_force_z),
    .in_ref_torque_theta(in_ref_torque_theta), .in_ref_torque_psi(in_ref_torque_psi),
    .in_meas_force_x(in_meas_force_x), .in_meas_force_z(in_meas_force_z),
    .in_meas_torque_y(in_meas_torque_y), .in_meas_torque_z(in_meas_torque_z),
    .in_pin_value(in_pin_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_z(out_pos_z),
    .out_pos_theta(out_pos_theta), .out_pos_psi(out_pos_psi),
    .out_vel_x(out_vel_x), .out_vel_z(out_vel_z),
    .out_vel_theta(out_vel_theta), .out_vel_psi(out_vel_psi),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  admittance_pose_checker pose_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_ref_force_x(in_ref_force_x), .in_ref_force_z(in_ref_force_z),
    .in_ref_torque_theta(in_ref_torque_theta), .in_ref_torque_psi(in_ref_torque_psi),
    .in_meas_force_x(in_meas_force_x), .in_meas_force_z(in_meas_force_z),
    .in_meas_torque_y(in_meas_torque_y), .in_meas_torque_z(in_meas_torque_z),
    .in_pin_value(in_pin_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_z(out_pos_z),
    .out_pos_theta(out_pos_theta), .out_pos_psi(out_pos_psi),
    .out_vel_x(out_vel_x), .out_vel_z(out_vel_z),
    .out_vel_theta(out_vel_theta), .out_vel_psi(out_vel_psi),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  // Receiver: one decision per cycle, made at the falling edge.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Mix of rails, small, medium and fully random Q16.16 values.
  function automatic logic [PORT_W-1:0] pick_value();
    logic [PORT_W-1:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom_range(1) ? Q_NEG_LSB : '0;
      3, 4: return raw;
      5, 6: return {{12{raw[19]}}, raw[19:0]};
      default: return {{8{raw[23]}}, raw[23:0]};
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] small_lanes(input int hi);
    logic [CFG_DATA_W-1:0] v;
    for (int a = 0; a < FIELD_AXES; a++) v[a*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, hi));
    return v;
  endfunction

  // Present one request, hold it until taken, and return on the next falling edge.
  // A random gap before it drops valid first; with no gap valid simply stays high.
  task automatic push_request(input action_t act,
                              input logic [FIELD_AXES-1:0][PORT_W-1:0] goal,
                              input logic [FIELD_AXES-1:0][PORT_W-1:0] sensed,
                              input logic pin);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action           <= act;
    in_ref_force_x      <= goal[0];
    in_ref_force_z      <= goal[1];
    in_ref_torque_theta <= goal[2];
    in_ref_torque_psi   <= goal[3];
    in_meas_force_x     <= sensed[0];
    in_meas_force_z     <= sensed[1];
    in_meas_torque_y    <= sensed[2];
    in_meas_torque_z    <= sensed[3];
    in_pin_value        <= pin;
    in_valid            <= 1'b1;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    @(negedge clk);
  endtask

  // Mostly reference steps, with measurements and flag flips mixed in; every
  // field carries random content, used or not.
  task automatic push_random();
    logic [FIELD_AXES-1:0][PORT_W-1:0] goal, sensed;
    action_t act;
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) act = ACT_MEASURE;
    else if (pick < 18) act = ACT_ACTIVATION;
    else if (pick < 24) act = ACT_SATURATION;
    else act = ACT_REFERENCE;
    for (int a = 0; a < FIELD_AXES; a++) begin
      goal[a]   = pick_value();
      sensed[a] = pick_value();
    end
    push_request(act, goal, sensed, 1'($urandom_range(1)));
  endtask

  // Drop valid and hold off until every predicted pose has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_valid high between back-to-back writes; the caller drops it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // One coefficient setting per round, rails included; end with a write to an
  // unmapped index, which the block must ignore.
  task automatic program_round(input int r);
    logic [CFG_DATA_W-1:0] k, d, m, ts_word;
    k = STIFFNESS_RESET;
    d = DAMPING_RESET;
    m = INV_MASS_RESET;
    ts_word = CFG_DATA_W'(STEP_TIME_RESET);
    case (r)
      1: begin
        k = '1; d = '1; m = '1; ts_word = 64'h0000_0000_0000_FFFF;
      end
      2: begin
        k = '0; d = '0; m = '0; ts_word = '0;   // zero step leaves the state frozen
      end
      3: begin
        k = {$urandom, $urandom}; d = {$urandom, $urandom}; m = {$urandom, $urandom};
        ts_word = CFG_DATA_W'($urandom_range(1, 65535));
      end
      4: begin
        k = small_lanes(16'h0400); d = small_lanes(16'h0400); m = small_lanes(16'h0200);
        ts_word = CFG_DATA_W'($urandom_range(1, 4096));
      end
      5: begin
        k = {$urandom, $urandom}; d = {$urandom, $urandom}; m = {$urandom, $urandom};
        ts_word = CFG_DATA_W'(1);
      end
      6: begin
        k = '1; d = '0; m = {$urandom, $urandom};
        // upper bits of the step word are junk the block must drop
        ts_word = {$urandom, 16'($urandom), 16'($urandom_range(1, 65535))};
      end
      7: begin
        k = small_lanes(16'h2000); d = {$urandom, $urandom};
      end
      default: ;
    endcase
    write_register(REG_STIFFNESS, k);
    write_register(REG_DAMPING, d);
    write_register(REG_INV_MASS, m);
    write_register(REG_STEP_TIME, ts_word);
    write_register(REG_STEP_TIME + CFG_IDX_W'(1) + CFG_IDX_W'(r % 4), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int wait_cycles;
    int directed_count;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reference before any measurement yields nothing, then rail
    // measurements and references so the error clamps both ways.
    push_request(ACT_REFERENCE, {4{Q_MAX}}, '0, 1'b0);
    push_request(ACT_ACTIVATION, '0, '0, 1'b1);
    push_request(ACT_MEASURE, '0, {Q_NEG_LSB, 32'd0, Q_MAX, Q_MIN}, 1'b0);
    repeat (5) push_request(ACT_REFERENCE, {32'd0, 32'd1, Q_MIN, Q_MAX}, '0, 1'b0);
    // Saturation on, then push back the other way so some axes try to grow.
    push_request(ACT_SATURATION, '0, '0, 1'b1);
    repeat (3) push_request(ACT_REFERENCE, {32'd0, 32'd1, Q_MAX, Q_MIN}, '0, 1'b0);
    push_request(ACT_REFERENCE, {Q_MIN, Q_MAX, Q_MIN, Q_MAX}, {4{Q_NEG_LSB}}, 1'b1);
    // Activation off: the error term is forced to zero.
    push_request(ACT_ACTIVATION, {4{Q_NEG_LSB}}, {4{Q_NEG_LSB}}, 1'b0);
    push_request(ACT_REFERENCE, {4{Q_MAX}}, '0, 1'b0);
    push_request(ACT_SATURATION, '0, '0, 1'b0);
    push_request(ACT_REFERENCE, {4{Q_MIN}}, '0, 1'b0);
    push_request(ACT_MEASURE, '0, '0, 1'b0);
    push_request(ACT_ACTIVATION, '0, '0, 1'b1);
    push_request(ACT_REFERENCE, {4{32'h0001_0000}}, '0, 1'b0);
    push_request(ACT_REFERENCE, '0, '0, 1'b0);
    directed_count = requests_sent;

    // Random rounds: new coefficients each round, cycling through no idling,
    // sender gaps, receiver stalls, and both at once.
    for (int r = 0; r < ROUNDS; r++) begin
      drain();
      program_round(r);
      case (r % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int n = 0; n < ROUND_REQUESTS; n++) begin
        // Mid-round, let the result queue run dry under receiver stalls.
        if (r == 2 && n == ROUND_REQUESTS / 2) drain();
        push_random();
      end
    end

    // Wind down: stop sending, wait for the tail of results, then settle.
    in_valid <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 4000 && pending != 0; wait_cycles++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d requests (%0d directed) over %0d coefficient settings,",
             requests_sent, directed_count, ROUNDS);
    $display("idle/stall mixes up to 48 percent; %0d poses checked, %0d mismatches.",
             checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
